// File: sv/upd_pkg.sv
// Package for the URL percent decoder: result word type, decode state codes,
// character constants, config indexes, queue geometry and the hex digit mapping.
// No dependencies.
package upd_pkg;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
  localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_IS_EQUALS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUS_TO_SPACE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COPY_PARTIAL_ESCAPE = 2'd2;

  // Result queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Escape decode phase
  typedef enum logic [2:0] {
    PH_TEXT  = 3'b001,
    PH_ESC   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  // One result word
  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       out_last;
    logic       is_partial;
  } result_t;

  // Map one hex digit, 8-bit wraparound, no range check
  function automatic logic [7:0] hex_value(input logic [7:0] d);
    logic [7:0] v;
    if (d >= CH_UPPER_A) begin
      v = d - HEX_ALPHA_OFS;
    end else begin
      v = d - HEX_DIGIT_OFS;
    end
    return v;
  endfunction

endpackage

// File: sv/upd_if.sv
// Stream interfaces for the URL percent decoder: encoded byte channel and
// decoded result channel. No dependencies.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       out_last;
  logic       is_partial;

  modport source (output valid, output out_char, output has_char, output out_last,
                  output is_partial, input ready);
  modport sink   (input valid, input out_char, input has_char, input out_last,
                  input is_partial, output ready);
endinterface

// File: sv/url_percent_decoder.sv
// Top level of the URL percent decoder.
// Depends on upd_pkg and on the upd_in_if / upd_out_if interfaces.
//
// Streaming decoder for percent-encoded or '='-escaped text.
// Channels: in_ch carries one encoded byte per word with a last-of-string
// mark; out_ch carries decoded words (out_char, has_char, out_last,
// is_partial). Both use valid/ready; a word moves when both are high.
// Configuration: cfg_we/cfg_index/cfg_data write one 1-bit register per
// cycle (0 escape_is_equals, 1 plus_to_space, 2 copy_partial_escape).
// Timing: an accepted byte waits in the input register and is decoded into a
// four-entry result queue once two queue slots are free; its first result is
// then shown on out_ch from the queue head.
// Throughput: one byte per cycle while the queue has room. Each byte yields
// zero, one or two results; the queue drains one result per cycle while
// out_ch.ready is high, so a two-result byte (truncated escape tail) fills two slots.
// Stall: while the receiver holds ready low, the queue fills; the input
// register stays full and in_ch.ready drops once fewer than two queue slots
// are free. Nothing is lost.
// Reset: synchronous rst empties the queue and input register, returns the
// decoder to plain text and loads the register defaults ('%', plus to space
// on, partial escape copy on).
module url_percent_decoder (
  input  logic                           clk,
  input  logic                           rst,
  upd_in_if.sink                         in_ch,
  upd_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [upd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic                           cfg_data
);

  // Configuration registers
  logic escape_is_equals;
  logic plus_to_space;
  logic copy_partial_escape;

  // Input register
  logic       held_valid;
  logic [7:0] held_char;
  logic       held_last;

  // Decode state
  upd_pkg::phase_t phase, phase_next;
  logic [7:0]      first_digit, first_digit_next;
  logic            stopped, stopped_next;

  // Result queue
  upd_pkg::result_t                q [upd_pkg::QDEPTH];
  logic [upd_pkg::QPTR_W-1:0]      wr_ptr;
  logic [upd_pkg::QPTR_W-1:0]      rd_ptr;
  logic [upd_pkg::QCNT_W-1:0]      count;

  logic             advance;
  logic             pop;
  logic [1:0]       n_res;
  upd_pkg::result_t res0, res1;
  logic [7:0]       esc;
  logic [7:0]       hi_val, lo_val;
  logic             in_take;

  // Hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_is_equals    <= 1'b0;
      plus_to_space       <= 1'b1;
      copy_partial_escape <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        upd_pkg::CFG_ESCAPE_IS_EQUALS:    escape_is_equals    <= cfg_data;
        upd_pkg::CFG_PLUS_TO_SPACE:       plus_to_space       <= cfg_data;
        upd_pkg::CFG_COPY_PARTIAL_ESCAPE: copy_partial_escape <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the held word when two queue slots are free
  assign advance      = held_valid && (count <= upd_pkg::QCNT_W'(upd_pkg::QDEPTH - 2));
  assign in_ch.ready  = !held_valid || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ch.ready) begin
      held_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_char <= in_ch.in_char;
      held_last <= in_ch.in_last;
    end
  end

  // Decode one byte against the current phase
  assign esc    = escape_is_equals ? upd_pkg::CH_EQUALS : upd_pkg::CH_PERCENT;
  assign hi_val = upd_pkg::hex_value(first_digit);
  assign lo_val = upd_pkg::hex_value(held_char);

  always_comb begin
    phase_next       = phase;
    first_digit_next = first_digit;
    stopped_next     = stopped;
    n_res            = 2'd0;
    res0             = '{out_char: upd_pkg::CH_NUL, has_char: 1'b0, out_last: 1'b1,
                         is_partial: 1'b0};
    res1             = res0;
    if (stopped) begin
      if (held_last) begin
        stopped_next = 1'b0;
        phase_next   = upd_pkg::PH_TEXT;
      end
    end else begin
      unique case (phase)
        upd_pkg::PH_ESC: begin
          first_digit_next = held_char;
          if (!held_last) begin
            phase_next = upd_pkg::PH_DIGIT;
          end else begin
            phase_next = upd_pkg::PH_TEXT;
            if (copy_partial_escape) begin
              n_res = 2'd2;
              res0  = '{out_char: esc, has_char: 1'b1, out_last: 1'b0, is_partial: 1'b1};
              res1  = '{out_char: held_char, has_char: 1'b1, out_last: 1'b1,
                        is_partial: 1'b1};
            end else begin
              n_res = 2'd1;
            end
          end
        end
        upd_pkg::PH_DIGIT: begin
          phase_next = upd_pkg::PH_TEXT;
          n_res      = 2'd1;
          res0       = '{out_char: {hi_val[3:0], lo_val[3:0]}, has_char: 1'b1,
                         out_last: held_last, is_partial: 1'b0};
        end
        default: begin
          phase_next = upd_pkg::PH_TEXT;
          if (held_char == esc) begin
            if (!held_last) begin
              phase_next = upd_pkg::PH_ESC;
            end else begin
              n_res = 2'd1;
              if (copy_partial_escape) begin
                res0 = '{out_char: esc, has_char: 1'b1, out_last: 1'b1, is_partial: 1'b1};
              end
            end
          end else if (held_char == upd_pkg::CH_NUL) begin
            n_res        = 2'd1;
            stopped_next = !held_last;
          end else if (held_char == upd_pkg::CH_PLUS && plus_to_space) begin
            n_res = 2'd1;
            res0  = '{out_char: upd_pkg::CH_SPACE, has_char: 1'b1, out_last: held_last,
                      is_partial: 1'b0};
          end else begin
            n_res = 2'd1;
            res0  = '{out_char: held_char, has_char: 1'b1, out_last: held_last,
                      is_partial: 1'b0};
          end
        end
      endcase
    end
  end

  // Advance decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= upd_pkg::PH_TEXT;
      first_digit <= 8'd0;
      stopped     <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      first_digit <= first_digit_next;
      stopped     <= stopped_next;
    end
  end

  // Push results into the queue
  always_ff @(posedge clk) begin
    if (advance && n_res != 2'd0) begin
      q[wr_ptr] <= res0;
    end
    if (advance && n_res == 2'd2) begin
      q[wr_ptr + upd_pkg::QPTR_W'(1)] <= res1;
    end
  end

  assign pop = out_ch.valid && out_ch.ready;

  // Track queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + upd_pkg::QPTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + upd_pkg::QPTR_W'(1);
      end
      count <= count + (advance ? upd_pkg::QCNT_W'(n_res) : '0)
                     - upd_pkg::QCNT_W'(pop);
    end
  end

  // Drive the result channel from the queue head
  assign out_ch.valid      = (count != '0);
  assign out_ch.out_char   = q[rd_ptr].out_char;
  assign out_ch.has_char   = q[rd_ptr].has_char;
  assign out_ch.out_last   = q[rd_ptr].out_last;
  assign out_ch.is_partial = q[rd_ptr].is_partial;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= upd_pkg::QCNT_W'(upd_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_stopped_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && stopped) |-> (n_res == 2'd0))
    else $error("result produced while stopped");

  a_two_only_tail: assert property (@(posedge clk) disable iff (rst)
    (advance && n_res == 2'd2) |-> (phase == upd_pkg::PH_ESC && held_last
                                    && copy_partial_escape))
    else $error("two results outside a truncated escape tail");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule
